>>> rtl/blf_pkg.sv
// ----------------------------------------------------------------------------
// blf_pkg
// Shared types, constants and command structures of the balancing line
// follower controller.
// ----------------------------------------------------------------------------
package blf_pkg;

  localparam int NumRegs = 8;
  localparam int RegIdxW = 3;

  localparam logic [RegIdxW-1:0] REG_PITCH_KP = 3'd0;
  localparam logic [RegIdxW-1:0] REG_PITCH_KI = 3'd1;
  localparam logic [RegIdxW-1:0] REG_PITCH_KD = 3'd2;
  localparam logic [RegIdxW-1:0] REG_YAW_KP   = 3'd3;
  localparam logic [RegIdxW-1:0] REG_YAW_KI   = 3'd4;
  localparam logic [RegIdxW-1:0] REG_YAW_KD   = 3'd5;
  localparam logic [RegIdxW-1:0] REG_BAL_REF  = 3'd6;
  localparam logic [RegIdxW-1:0] REG_FWD_REF  = 3'd7;

  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_BWD  = 2'd2;

  localparam logic signed [15:0] HeldRefReset = 16'sd1536;

  typedef struct packed {
    logic signed [15:0] tilt;
    logic [11:0]        line_sensor_a;
    logic [11:0]        line_sensor_b;
    logic [11:0]        line_sensor_c;
    logic [11:0]        line_sensor_d;
  } blf_in_t;

  typedef struct packed {
    logic [1:0]         motor_direction;
    logic [14:0]        left_duty;
    logic [14:0]        right_duty;
    logic signed [15:0] angle_reference;
    logic               is_balanced;
  } blf_out_t;

  typedef struct packed {
    logic [RegIdxW-1:0] index;
    logic [15:0]        data;
  } blf_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture input item
    logic prod;      // compute pitch products
    logic pitch;     // pitch correction
    logic sense;     // sensor mapping
    logic div_start; // start position division
    logic yaw;       // yaw products
    logic finish;    // mode machine, state update, result
  } blf_cmd_t;

  typedef struct packed {
    logic div_done;
  } blf_sts_t;

endpackage

>>> rtl/blf_div.sv
// ----------------------------------------------------------------------------
// blf_div
// Restoring divider, one quotient bit a cycle, unsigned 30 by 20 bits.
// ----------------------------------------------------------------------------
module blf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [29:0] dividend,
  input  logic [19:0] divisor,
  output logic        done,
  output logic [29:0] quotient
);

  logic [4:0]  count;
  logic        busy;
  logic [20:0] rem;
  logic [29:0] quo;
  logic [20:0] trial;
  logic [19:0] dvs;

  assign trial = {rem[19:0], quo[29]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 5'd30;
      end else if (busy) begin
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, dvs}) begin
        rem <= trial - {1'b0, dvs};
        quo <= {quo[28:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[28:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

>>> rtl/blf_datapath.sv
// ----------------------------------------------------------------------------
// blf_datapath
// Pitch and yaw PID arithmetic, sensor mapping, line position and mode state.
// ----------------------------------------------------------------------------
module blf_datapath (
  input  logic             clk,
  input  logic             rst,
  input  blf_pkg::blf_cmd_t cmd,
  output blf_pkg::blf_sts_t sts,
  input  blf_pkg::blf_in_t  in_item,
  input  logic             cfg_we,
  input  blf_pkg::blf_cfg_t cfg,
  output blf_pkg::blf_out_t result
);
  import blf_pkg::*;

  logic [15:0] regs [NumRegs];

  logic signed [15:0] pitch_last_error;
  logic signed [31:0] pitch_accumulator;
  logic signed [15:0] yaw_last_error;
  logic signed [13:0] yaw_accumulator;
  logic               balanced_mode;
  logic [14:0]        held_left_duty;
  logic [14:0]        held_right_duty;
  logic signed [15:0] held_reference;

  blf_in_t            item;
  logic signed [31:0] acc_new;
  logic signed [48:0] p_kp, p_kd, p_ki;
  logic signed [15:0] mag;
  logic [17:0]        sv [4];
  logic               any_white;
  logic signed [15:0] pos;
  logic signed [19:0] err10, yacc;
  logic signed [37:0] y_kp, y_ki, y_kd;

  // sum clamp of pitch accumulator
  logic signed [32:0] acc_sum;
  assign acc_sum = 33'(pitch_accumulator) + 33'(item.tilt);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NumRegs; i++) begin
        case (i)
          0: regs[i] <= 16'd1498;
          1: regs[i] <= 16'd24;
          2: regs[i] <= 16'd973;
          3: regs[i] <= 16'd512;
          4: regs[i] <= 16'd0;
          5: regs[i] <= 16'd256;
          6: regs[i] <= 16'd1536;
          default: regs[i] <= 16'd1920;
        endcase
      end
    end else if (cfg_we) begin
      regs[cfg.index] <= cfg.data;
    end
  end

  // --- pitch products
  logic signed [16:0] diff;
  assign diff = 17'(item.tilt) - 17'(pitch_last_error);

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_item;
    if (cmd.prod) begin
      if (acc_sum > 33'sh0_7FFF_FFFF) acc_new <= 32'sh7FFF_FFFF;
      else if (acc_sum < -33'sh0_8000_0000) acc_new <= 32'sh8000_0000;
      else acc_new <= acc_sum[31:0];
      p_kp <= 49'($signed({1'b0, regs[REG_PITCH_KP]}) * item.tilt);
      p_kd <= 49'($signed({1'b0, regs[REG_PITCH_KD]}) * diff);
    end
  end

  // pitch correction
  logic signed [48:0] p_int_full;
  logic signed [40:0] integ_s, pd_s;
  logic signed [41:0] corr, cabs;
  always_comb begin
    p_int_full = 49'($signed({1'b0, regs[REG_PITCH_KI]}) * acc_new);
    integ_s = 41'(p_int_full >>> 8);
    if (integ_s > 41'sd19200) integ_s = 41'sd19200;
    else if (integ_s < -41'sd19200) integ_s = -41'sd19200;
    pd_s = 41'((p_kp + p_kd) >>> 8);
    corr = 42'(pd_s) + 42'(integ_s);
    cabs = corr < 0 ? -corr : corr;
  end

  always_ff @(posedge clk) begin
    if (cmd.pitch) begin
      p_ki <= p_int_full;
      mag  <= (cabs > 42'sd20480) ? 16'sd20480 : 16'(cabs);
    end
  end

  // --- sensor mapping: (raw-1700)*256000/2300 = (raw-1700)*2560/23
  logic [19:0] scaled [4];
  logic [11:0] raw [4];
  assign raw[0] = item.line_sensor_a;
  assign raw[1] = item.line_sensor_b;
  assign raw[2] = item.line_sensor_c;
  assign raw[3] = item.line_sensor_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      // divide by 23 via reciprocal: 2^28/23 rounded up, exact for x below 2^28/5
      logic [22:0] num;
      logic [46:0] pr;
      num = (raw[i] > 12'd1700) ? 23'(raw[i] - 12'd1700) * 23'd2560 : 23'd0;
      pr = 47'(num) * 47'd11671107;
      scaled[i] = 20'(pr >> 28);
    end
  end

  logic signed [21:0] wsum;
  logic [19:0]        vsum;
  always_ff @(posedge clk) begin
    if (cmd.sense) begin
      for (int i = 0; i < 4; i++)
        sv[i] <= (scaled[i] > 20'd256000) ? 18'd256000 : scaled[i][17:0];
    end
  end

  always_comb begin
    wsum = -22'sd3 * $signed({4'b0, sv[0]}) - $signed({4'b0, sv[1]})
           + $signed({4'b0, sv[2]}) + 22'sd3 * $signed({4'b0, sv[3]});
    vsum = 20'(sv[0]) + 20'(sv[1]) + 20'(sv[2]) + 20'(sv[3]);
    any_white = 1'b0;
    for (int i = 0; i < 4; i++)
      if (sv[i] > 18'd102400) any_white = 1'b1;
  end

  // position division: |wsum|*256 / vsum
  logic        neg;
  logic [29:0] div_q;
  logic [29:0] numer;
  logic        div_done;
  assign numer = 30'(wsum < 0 ? -wsum : wsum) << 8;

  always_ff @(posedge clk) begin
    if (cmd.div_start) neg <= wsum < 0;
  end

  blf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (numer),
    .divisor  (vsum),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sts.div_done = div_done;

  // yaw
  logic signed [15:0] pos_c;
  logic signed [19:0] e10_c, yacc_c, ysum;
  always_comb begin
    if (!any_white) pos_c = (yaw_last_error > 0) ? 16'sd7680 : -16'sd7680;
    else if (vsum == 0) pos_c = '0;
    else pos_c = neg ? -16'(div_q) : 16'(div_q);
    e10_c = 20'(pos_c) * 20'sd10;
    ysum = 20'(yaw_accumulator) + e10_c;
    if (ysum > 20'sd7680) yacc_c = 20'sd7680;
    else if (ysum < -20'sd7680) yacc_c = -20'sd7680;
    else yacc_c = ysum;
  end

  always_ff @(posedge clk) begin
    if (cmd.yaw) begin
      pos   <= pos_c;
      err10 <= e10_c;
      yacc  <= yacc_c;
      y_kp  <= 38'($signed({1'b0, regs[REG_YAW_KP]}) * e10_c);
      y_ki  <= 38'($signed({1'b0, regs[REG_YAW_KI]}) * yacc_c);
      y_kd  <= 38'($signed({1'b0, regs[REG_YAW_KD]})
                   * (21'(e10_c) - 21'(yaw_last_error) * 21'sd10));
    end
  end

  // mode machine
  logic signed [30:0] ycorr, ycs, lsum, rsum;
  logic [14:0] hld, lcl, rcl, lo_d, ro_d;
  logic [1:0]  dir;
  logic        bal_n;
  logic signed [15:0] ref_n;
  logic signed [15:0] e;
  assign e = item.tilt;

  function automatic logic [14:0] dclamp(input logic signed [30:0] v);
    if (v < 31'sd15360) return 15'd15360;
    else if (v > 31'sd23040) return 15'd23040;
    else return v[14:0];
  endfunction

  always_comb begin
    ycorr = 31'((40'(y_kp) + 40'(y_ki) + 40'(y_kd)) >>> 8);
    ycs  = (e > 0) ? ycorr : -ycorr;
    lsum = 31'(mag) + ycs;
    rsum = 31'(mag) - ycs;
    hld  = dclamp(31'(mag));
    lcl  = dclamp(lsum);
    rcl  = dclamp(rsum);
    bal_n = balanced_mode;
    ref_n = held_reference;
    if (!balanced_mode) begin
      if (e > 16'sd256) dir = DIR_FWD;
      else if (e < -16'sd256) dir = DIR_BWD;
      else begin
        dir = DIR_STOP;
        ref_n = $signed(regs[REG_FWD_REF]);
        bal_n = 1'b1;
      end
      lo_d = held_left_duty;
      ro_d = held_right_duty;
    end else begin
      lo_d = lcl;
      ro_d = rcl;
      dir = (e > 0) ? DIR_FWD : ((e < 0) ? DIR_BWD : DIR_STOP);
      if (e > 16'sd128 || e < -16'sd640) begin
        ref_n = $signed(regs[REG_BAL_REF]);
        bal_n = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_last_error  <= '0;
      pitch_accumulator <= '0;
      yaw_last_error    <= '0;
      yaw_accumulator   <= '0;
      balanced_mode     <= 1'b0;
      held_left_duty    <= '0;
      held_right_duty   <= '0;
      held_reference    <= HeldRefReset;
    end else if (cmd.finish) begin
      pitch_last_error  <= e;
      pitch_accumulator <= acc_new;
      yaw_last_error    <= pos;
      yaw_accumulator   <= 14'(yacc);
      balanced_mode     <= bal_n;
      held_left_duty    <= balanced_mode ? lcl : hld;
      held_right_duty   <= balanced_mode ? rcl : hld;
      held_reference    <= ref_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.motor_direction <= dir;
      result.left_duty       <= (dir == DIR_STOP) ? 15'd0 : lo_d;
      result.right_duty      <= (dir == DIR_STOP) ? 15'd0 : ro_d;
      result.angle_reference <= ref_n;
      result.is_balanced     <= bal_n;
    end
  end

  logic unused;
  assign unused = ^{p_ki, err10};

endmodule

>>> rtl/blf_ctrl.sv
// ----------------------------------------------------------------------------
// blf_ctrl
// Sequencer of one control step and the output handshake.
// ----------------------------------------------------------------------------
module blf_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output blf_pkg::blf_cmd_t cmd,
  input  blf_pkg::blf_sts_t sts
);
  import blf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PROD  = 8'b0000_0010,
    S_PITCH = 8'b0000_0100,
    S_SENSE = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_WAIT  = 8'b0010_0000,
    S_YAW   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;

  // a new item may enter once the previous result has left or leaves now
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    cmd = '0;
    state_next = state;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          state_next = S_PROD;
        end
      end
      S_PROD: begin
        cmd.prod = 1'b1;
        state_next = S_PITCH;
      end
      S_PITCH: begin
        cmd.pitch = 1'b1;
        state_next = S_SENSE;
      end
      S_SENSE: begin
        cmd.sense = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (sts.div_done) state_next = S_YAW;
      end
      S_YAW: begin
        cmd.yaw = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

>>> rtl/balance_line_follow_controller.sv
// ----------------------------------------------------------------------------
// balance_line_follow_controller
// Dual PID balancing line follower, one control step per input beat.
// ----------------------------------------------------------------------------
// Each input beat is accepted in the idle state, then steps through the
// product, pitch, sense, divider start, divider wait, yaw and finish
// states; the bit-serial line-position divider sets the rate. The
// result sits in an output register until taken; the next beat is accepted
// in the cycle the result leaves. Configuration writes are taken at any time
// and are meant for when the block is idle.
module balance_line_follow_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  blf_pkg::blf_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output blf_pkg::blf_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  blf_pkg::blf_cfg_t cfg_data
);
  import blf_pkg::*;

  blf_cmd_t cmd;
  blf_sts_t sts;

  assign cfg_ready = 1'b1;

  blf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  blf_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .in_item (in_data),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg     (cfg_data),
    .result  (out_data)
  );

endmodule

>>> rtl/blf_checker.sv
// ----------------------------------------------------------------------------
// blf_checker
// Port-level checks of the balancing line follower controller.
// ----------------------------------------------------------------------------
module blf_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input blf_pkg::blf_out_t out_data
);
  import blf_pkg::*;

  // no input beat while a result is stalled
  a_no_accept_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("accept while stalled");

  // a result never follows its input beat in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid) else $error("result too early");

  // stop always carries zero duty
  a_stop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.motor_direction == DIR_STOP
    |-> out_data.left_duty == 15'd0 && out_data.right_duty == 15'd0)
    else $error("stop with duty");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed");

endmodule

bind balance_line_follow_controller blf_checker u_blf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/sv/tb_balance_line_follow_controller.sv
// ----------------------------------------------------------------------------
// tb_balance_line_follow_controller
// Drives control steps through the balancing line follower, predicts each
// result from its own model of the pitch and yaw loops and the mode machine,
// and checks every result beat field by field under random idling on both
// sides and across several gain and reference settings.
// ----------------------------------------------------------------------------
module tb_balance_line_follow_controller;
  import blf_pkg::*;

  localparam int Q8 = 256;
  localparam longint CycleLimit = 2000000;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  blf_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  blf_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  blf_cfg_t cfg_data;

  balance_line_follow_controller dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state
  logic [15:0] gain [NumRegs];
  longint p_last, p_acc, y_last, y_acc, hold_l, hold_r, hold_ref;
  bit     bal;

  blf_out_t expected_steps [$];
  int     fail_count;
  longint cycle_count;
  int     send_idle_pct;
  int     recv_idle_pct;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic longint fshr8(longint v);
    return v >>> 8;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  task automatic reset_model();
    gain[REG_PITCH_KP] = 16'd1498;
    gain[REG_PITCH_KI] = 16'd24;
    gain[REG_PITCH_KD] = 16'd973;
    gain[REG_YAW_KP]   = 16'd512;
    gain[REG_YAW_KI]   = 16'd0;
    gain[REG_YAW_KD]   = 16'd256;
    gain[REG_BAL_REF]  = 16'd1536;
    gain[REG_FWD_REF]  = 16'd1920;
    p_last = 0; p_acc = 0; y_last = 0; y_acc = 0;
    hold_l = 0; hold_r = 0; hold_ref = 1536; bal = 0;
  endtask

  function automatic blf_out_t control_step(blf_in_t x);
    longint e, diff, integ, corr, mag, wsum, vsum, pos, err10, ycorr, l, r, ysg, num;
    longint raw, sv;
    longint w [4];
    int dir;
    bit white;
    blf_out_t o;
    w = '{-3, -1, 1, 3};
    wsum = 0; vsum = 0; white = 0;
    e = sx16(x.tilt);
    diff = e - p_last;
    p_acc = clip(p_acc + e, -64'sd2147483648, 64'sd2147483647);
    integ = clip(fshr8(p_acc * longint'(gain[REG_PITCH_KI])), -75 * Q8, 75 * Q8);
    corr = fshr8(longint'(gain[REG_PITCH_KP]) * e + longint'(gain[REG_PITCH_KD]) * diff)
           + integ;
    p_last = e;
    mag = clip(corr < 0 ? -corr : corr, 0, 80 * Q8);
    for (int i = 0; i < 4; i++) begin
      case (i)
        0: raw = x.line_sensor_a;
        1: raw = x.line_sensor_b;
        2: raw = x.line_sensor_c;
        default: raw = x.line_sensor_d;
      endcase
      sv = raw > 1700 ? ((raw - 1700) * 256000) / 2300 : 0;
      sv = clip(sv, 0, 1000 * Q8);
      if (sv > 400 * Q8) white = 1;
      wsum += sv * w[i];
      vsum += sv;
    end
    pos = 0;
    if (vsum != 0) begin
      num = wsum * Q8;
      pos = num < 0 ? -((-num) / vsum) : num / vsum;
    end
    if (!white) pos = y_last > 0 ? 30 * Q8 : -30 * Q8;
    err10 = pos * 10;
    y_acc = clip(y_acc + err10, -30 * Q8, 30 * Q8);
    ycorr = fshr8(longint'(gain[REG_YAW_KP]) * err10 + longint'(gain[REG_YAW_KI]) * y_acc
                  + longint'(gain[REG_YAW_KD]) * (err10 - y_last * 10));
    y_last = pos;
    if (!bal) begin
      if (e > Q8) dir = DIR_FWD;
      else if (e < -Q8) dir = DIR_BWD;
      else begin
        dir = DIR_STOP;
        hold_ref = sx16(gain[REG_FWD_REF]);
        bal = 1;
      end
      l = hold_l; r = hold_r;
      hold_l = clip(mag, 60 * Q8, 90 * Q8);
      hold_r = hold_l;
    end else begin
      ysg = e > 0 ? ycorr : -ycorr;
      l = clip(mag + ysg, 60 * Q8, 90 * Q8);
      r = clip(mag - ysg, 60 * Q8, 90 * Q8);
      hold_l = l; hold_r = r;
      dir = e > 0 ? DIR_FWD : (e < 0 ? DIR_BWD : DIR_STOP);
      if (e > Q8 / 2 || e < -(5 * Q8 / 2)) begin
        hold_ref = sx16(gain[REG_BAL_REF]);
        bal = 0;
      end
    end
    if (dir == DIR_STOP) begin
      l = 0; r = 0;
    end
    o.motor_direction = dir[1:0];
    o.left_duty = l[14:0];
    o.right_duty = r[14:0];
    o.angle_reference = hold_ref[15:0];
    o.is_balanced = bal;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    blf_out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_steps.size() == 0) begin
          report_mismatch("unexpected beat", 1, 0);
        end else begin
          want = expected_steps.pop_front();
          if (out_data.motor_direction !== want.motor_direction)
            report_mismatch("motor_direction", out_data.motor_direction,
                            want.motor_direction);
          if (out_data.left_duty !== want.left_duty)
            report_mismatch("left_duty", out_data.left_duty, want.left_duty);
          if (out_data.right_duty !== want.right_duty)
            report_mismatch("right_duty", out_data.right_duty, want.right_duty);
          if (out_data.angle_reference !== want.angle_reference)
            report_mismatch("angle_reference", out_data.angle_reference,
                            want.angle_reference);
          if (out_data.is_balanced !== want.is_balanced)
            report_mismatch("is_balanced", out_data.is_balanced, want.is_balanced);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // valid stays up after a beat until the next idle cycle or the drain
  task automatic send_step(blf_in_t x);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_steps.push_back(control_step(x));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_gain(logic [RegIdxW-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_data  <= '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    gain[idx] = val;
    @(posedge clk);
  endtask

  function automatic logic [11:0] rand_sensor();
    case ($urandom_range(5))
      0: return 12'd0;
      1: return 12'hFFF;
      2: return 12'($urandom_range(1700));
      3: return 12'($urandom_range(2620, 1700));
      default: return 12'($urandom());
    endcase
  endfunction

  function automatic blf_in_t rand_step(bit near_level);
    blf_in_t x;
    case ($urandom_range(9))
      0: x.tilt = 16'($urandom());
      1, 2: x.tilt = 16'($signed($urandom_range(46080)) - 23040);
      default: x.tilt = near_level ? 16'($signed($urandom_range(1280)) - 896)
                                   : 16'($signed($urandom_range(2048)) - 1024);
    endcase
    x.line_sensor_a = rand_sensor();
    x.line_sensor_b = rand_sensor();
    x.line_sensor_c = rand_sensor();
    x.line_sensor_d = rand_sensor();
    return x;
  endfunction

  function automatic blf_in_t mk(int ang, int a, int b, int c, int d);
    blf_in_t x;
    x.tilt = 16'(ang);
    x.line_sensor_a = 12'(a); x.line_sensor_b = 12'(b);
    x.line_sensor_c = 12'(c); x.line_sensor_d = 12'(d);
    return x;
  endfunction

  task automatic test_directed();
    send_step(mk(23040, 0, 0, 0, 0));          // backward-leaning start, no line
    send_step(mk(-23040, 4095, 0, 0, 0));
    send_step(mk(300, 0, 0, 0, 4095));         // just over one degree
    send_step(mk(0, 0, 2000, 2100, 0));        // level: stop, enter balanced mode
    send_step(mk(100, 1600, 1800, 1800, 1600));// no sensor above threshold
    send_step(mk(-100, 0, 0, 4095, 4095));
    send_step(mk(-640, 4095, 4095, 4095, 4095)); // exactly -2.5 degrees: stays balanced
    send_step(mk(256, 0, 0, 0, 0));            // exactly one degree in balanced mode: leave
    send_step(mk(0, 4095, 0, 0, 0));           // zero angle: stop, enter balanced mode
    send_step(mk(128, 2620, 0, 0, 0));
    send_step(mk(129, 0, 0, 0, 2620));         // just over +0.5 degrees
    send_step(mk(-256, 1700, 1701, 0, 0));
    send_step(mk(-32768, 4095, 4095, 0, 0));   // beyond field range
    send_step(mk(32767, 0, 4095, 4095, 0));
    send_step(mk(-1, 0, 0, 0, 0));
    for (int i = 0; i < 6; i++) send_step(mk(i * 40 - 100, 3000, 0, 0, 0));
    drain();
  endtask

  task automatic test_random(int n, bit near_level);
    for (int i = 0; i < n; i++) send_step(rand_step(near_level));
    drain();
  endtask

  task automatic test_settings();
    // extremes of every register, then random mid values
    for (int r = 0; r < NumRegs; r++) write_gain(r[RegIdxW-1:0], 16'hFFFF);
    test_random(150, 1);
    for (int r = 0; r < NumRegs; r++) write_gain(r[RegIdxW-1:0], 16'h0000);
    test_random(150, 1);
    write_gain(REG_BAL_REF, 16'h8000);
    write_gain(REG_FWD_REF, 16'h7FFF);
    for (int r = 0; r < 6; r++) write_gain(r[RegIdxW-1:0], 16'($urandom_range(4000)));
    test_random(200, 1);
    for (int r = 0; r < NumRegs; r++) write_gain(r[RegIdxW-1:0], 16'($urandom()));
    test_random(150, 0);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    cycle_count = 0;
    send_idle_pct = 11;
    recv_idle_pct = 50;
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(400, 1);
    send_idle_pct = 50;
    recv_idle_pct = 11;
    test_settings();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_gain(REG_PITCH_KP, 16'd1498);
    write_gain(REG_PITCH_KI, 16'd24);
    write_gain(REG_YAW_KI, 16'd40);
    test_random(730, 1);

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/blf_pkg.sv
rtl/blf_div.sv
rtl/blf_datapath.sv
rtl/blf_ctrl.sv
rtl/balance_line_follow_controller.sv
rtl/blf_checker.sv
tb/sv/tb_balance_line_follow_controller.sv
